// ===== hdl/tvs_pkg.sv =====
// Shared constants, codes and state type for the tag-value store.
package tvs_pkg;

    localparam int DEF_BUFFER_BYTES = 4096;
    localparam int DEF_MAX_TAGS     = 256;

    localparam int FW_CMD    = 2;
    localparam int FW_BYTE   = 8;
    localparam int FW_VLEN   = 13;
    localparam int FW_INDEX  = 12;
    localparam int FW_STATUS = 3;
    localparam int FW_TAG    = 16;
    localparam int FW_COUNT  = 9;

    localparam logic [4:0] ID_EXT_CODE = 5'h1F;

    typedef enum logic [FW_CMD-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_DIR    = 2'd3
    } t_cmd;

    typedef enum logic [FW_STATUS-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_NO_ROOM   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LEN,
        S_ACT,
        S_RBUF,
        S_MOVE,
        S_SHIFT,
        S_APPEND
    } t_state;

endpackage

// ===== hdl/tag_value_store_core.sv =====
// Top level of the tag-value store: command sequencer around directory and buffer memories.
//
// An item is taken when start is high and busy is low; its single result appears on the
// o_ ports for one cycle with o_done high and cannot be held off. An invalid tag, or a
// directory read beyond the stored count, answers in the next cycle. A tag lookup scans
// the directory memory one entry per cycle, then passes through S_LEN (on a match) and
// S_ACT; a directory read passes S_SCAN, S_LEN and S_ACT, a byte read adds S_RBUF for the
// buffer port. A delete, or a write run start that replaces a value of another length,
// then moves every byte stored after the removed value through the buffer's read and write
// ports (one byte per cycle) and shifts the later directory entries (one per cycle). No
// clearing pass is needed after reset: only entries below the stored count are ever used.
module tag_value_store_core
    import tvs_pkg::*;
#(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
    parameter int MAX_TAGS     = DEF_MAX_TAGS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tvs_pkg::FW_CMD-1:0]    i_cmd,
    input  logic [7:0]                    i_tag_first,
    input  logic [7:0]                    i_tag_second,
    input  logic [tvs_pkg::FW_VLEN-1:0]   i_value_length,
    input  logic [tvs_pkg::FW_INDEX-1:0]  i_byte_index,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_done,
    output logic [tvs_pkg::FW_STATUS-1:0] o_status,
    output logic [7:0]                    o_read_byte,
    output logic [tvs_pkg::FW_VLEN-1:0]   o_stored_length,
    output logic [tvs_pkg::FW_TAG-1:0]    o_tag_id,
    output logic [tvs_pkg::FW_COUNT-1:0]  o_entry_count
);
    localparam int OW   = $clog2(BUFFER_BYTES + 1);
    localparam int BW   = $clog2(BUFFER_BYTES);
    localparam int TW   = $clog2(MAX_TAGS + 1);
    localparam int AW   = $clog2(MAX_TAGS);
    localparam int CMPW = ((OW > FW_VLEN) ? OW : FW_VLEN) + 1;
    localparam logic [OW-1:0] BUF_END = OW'(BUFFER_BYTES);

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [FW_TAG-1:0]     r_id, n_id;
    logic [FW_INDEX-1:0]   r_idx, n_idx;
    logic [FW_VLEN-1:0]    r_vlen, n_vlen;
    logic [7:0]            r_data, n_data;
    logic [TW-1:0]         r_count, n_count;
    logic [OW-1:0]         r_end, n_end;
    t_status               r_ws, n_ws;
    logic [TW-1:0]         r_i, n_i;
    logic [TW-1:0]         r_k, n_k;
    logic                  r_found, n_found;
    logic                  r_after, n_after;
    logic [OW-1:0]         r_off, n_off;
    logic [OW-1:0]         r_len, n_len;
    logic [OW-1:0]         r_src, n_src;
    logic [OW-1:0]         r_dst, n_dst;
    logic                  r_pend, n_pend;

    logic                  r_ovalid, n_ovalid;
    t_status               r_ostatus, n_ostatus;
    logic [7:0]            r_orbyte, n_orbyte;
    logic [FW_VLEN-1:0]    r_oslen, n_oslen;
    logic [FW_TAG-1:0]     r_otid, n_otid;
    logic [FW_COUNT-1:0]   r_ocount, n_ocount;

    logic [FW_TAG-1:0]     w_id;
    t_cmd                  w_cmd;

    logic                  dir_we;
    logic [AW-1:0]         dir_waddr, dir_raddr;
    logic [15:0]           dir_wid, dir_rid;
    logic [OW-1:0]         dir_woff, dir_roff;
    logic                  buf_we;
    logic [BW-1:0]         buf_waddr, buf_raddr;
    logic [7:0]            buf_wdata, buf_rdata;

    tvs_dir_ram #(.DEPTH(MAX_TAGS), .AW(AW), .OW(OW)) u_dir (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wid   (dir_wid),
        .i_woff  (dir_woff),
        .i_raddr (dir_raddr),
        .o_rid   (dir_rid),
        .o_roff  (dir_roff)
    );

    tvs_buf_ram #(.DEPTH(BUFFER_BYTES), .AW(BW)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    assign w_id  = (i_tag_first[4:0] == ID_EXT_CODE) ? {i_tag_first, i_tag_second}
                                                     : {8'h00, i_tag_first};
    assign w_cmd = t_cmd'(i_cmd);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_id      = r_id;
        n_idx     = r_idx;
        n_vlen    = r_vlen;
        n_data    = r_data;
        n_count   = r_count;
        n_end     = r_end;
        n_ws      = r_ws;
        n_i       = r_i;
        n_k       = r_k;
        n_found   = r_found;
        n_after   = r_after;
        n_off     = r_off;
        n_len     = r_len;
        n_src     = r_src;
        n_dst     = r_dst;
        n_pend    = r_pend;
        n_ovalid  = 1'b0;
        n_ostatus = r_ostatus;
        n_orbyte  = r_orbyte;
        n_oslen   = r_oslen;
        n_otid    = r_otid;
        n_ocount  = r_ocount;
        dir_we    = 1'b0;
        dir_waddr = '0;
        dir_wid   = r_id;
        dir_woff  = r_end;
        dir_raddr = '0;
        buf_we    = 1'b0;
        buf_waddr = '0;
        buf_wdata = r_data;
        buf_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = w_cmd;
                    n_id     = w_id;
                    n_idx    = i_byte_index;
                    n_vlen   = i_value_length;
                    n_data   = i_data_byte;
                    n_found  = 1'b0;
                    n_len    = '0;
                    n_after  = 1'b0;
                    n_orbyte = '0;
                    n_oslen  = '0;
                    n_otid   = w_id;
                    n_ocount = FW_COUNT'(r_count);
                    if (w_cmd == CMD_DIR) begin
                        if (CMPW'(i_byte_index) < CMPW'(r_count)) begin
                            n_i       = TW'(i_byte_index);
                            dir_raddr = AW'(i_byte_index);
                            n_state   = S_SCAN;
                        end else begin
                            n_ovalid  = 1'b1;
                            n_ostatus = ST_NOT_FOUND;
                            n_otid    = '0;
                        end
                    end else if (w_id == '0) begin
                        n_ovalid  = 1'b1;
                        n_ostatus = ST_INVALID;
                        if (w_cmd == CMD_WRITE && i_byte_index == '0) begin
                            n_ws = ST_INVALID;
                        end
                    end else begin
                        n_i       = '0;
                        dir_raddr = '0;
                        n_state   = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // read data always belongs to r_i; the next address is issued each cycle
                if (CMPW'(r_i) >= CMPW'(r_count)) begin
                    n_state = S_ACT;
                end else if (r_cmd == CMD_DIR || dir_rid == r_id) begin
                    n_k       = r_i;
                    n_off     = dir_roff;
                    if (r_cmd == CMD_DIR) begin
                        n_id = dir_rid;
                    end
                    dir_raddr = AW'(r_i + 1'b1);
                    n_state   = S_LEN;
                end else begin
                    n_i       = r_i + 1'b1;
                    dir_raddr = AW'(r_i + 1'b1);
                end
            end

            S_LEN: begin
                // last entry ends at the fill mark
                n_len   = (((r_k + 1'b1) == r_count) ? r_end : dir_roff) - r_off;
                n_found = 1'b1;
                n_state = S_ACT;
            end

            S_ACT: begin
                n_orbyte = '0;
                n_oslen  = '0;
                n_otid   = r_id;
                n_ocount = FW_COUNT'(r_count);
                n_src    = r_off + r_len;
                n_dst    = r_off;
                n_pend   = 1'b0;
                case (r_cmd)
                    CMD_DIR: begin
                        n_ovalid  = 1'b1;
                        n_ostatus = ST_OK;
                        n_oslen   = FW_VLEN'(r_len);
                        n_state   = S_IDLE;
                    end
                    CMD_READ: begin
                        if (!r_found) begin
                            n_ovalid  = 1'b1;
                            n_ostatus = ST_NOT_FOUND;
                            n_state   = S_IDLE;
                        end else if (CMPW'(r_idx) < CMPW'(r_len)) begin
                            buf_raddr = BW'(CMPW'(r_off) + CMPW'(r_idx));
                            n_state   = S_RBUF;
                        end else begin
                            n_ovalid  = 1'b1;
                            n_ostatus = ST_OK;
                            n_oslen   = FW_VLEN'(r_len);
                            n_state   = S_IDLE;
                        end
                    end
                    CMD_DELETE: begin
                        if (!r_found) begin
                            n_ovalid  = 1'b1;
                            n_ostatus = ST_NOT_FOUND;
                            n_state   = S_IDLE;
                        end else begin
                            n_after = 1'b0;
                            n_state = S_MOVE;
                        end
                    end
                    default: begin
                        if (r_idx == '0) begin
                            if (r_found && CMPW'(r_len) == CMPW'(r_vlen)) begin
                                // same length: overwrite in place
                                if (r_len != '0) begin
                                    buf_we    = 1'b1;
                                    buf_waddr = BW'(r_off);
                                end
                                n_ws      = ST_OK;
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_OK;
                                n_oslen   = FW_VLEN'(r_len);
                                n_state   = S_IDLE;
                            end else if (r_found) begin
                                n_after = 1'b1;
                                n_state = S_MOVE;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end else begin
                            n_ovalid  = 1'b1;
                            n_state   = S_IDLE;
                            n_ostatus = r_ws;
                            if (r_found) begin
                                n_oslen = FW_VLEN'(r_len);
                                if (r_ws == ST_OK && CMPW'(r_idx) < CMPW'(r_len)) begin
                                    buf_we    = 1'b1;
                                    buf_waddr = BW'(CMPW'(r_off) + CMPW'(r_idx));
                                end
                            end else if (r_ws == ST_OK) begin
                                n_ws      = ST_NOT_FOUND;
                                n_ostatus = ST_NOT_FOUND;
                            end
                        end
                    end
                endcase
            end

            S_RBUF: begin
                n_ovalid  = 1'b1;
                n_ostatus = ST_OK;
                n_orbyte  = buf_rdata;
                n_oslen   = FW_VLEN'(r_len);
                n_state   = S_IDLE;
            end

            S_MOVE: begin
                // close the gap: read ahead at r_src, write the byte back at r_dst
                if (r_pend) begin
                    buf_we    = 1'b1;
                    buf_waddr = BW'(r_dst);
                    buf_wdata = buf_rdata;
                    n_dst     = r_dst + 1'b1;
                end
                if (r_src < r_end) begin
                    buf_raddr = BW'(r_src);
                    n_src     = r_src + 1'b1;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_i       = r_k;
                        dir_raddr = AW'(r_k + 1'b1);
                        n_state   = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                if ((r_i + 1'b1) < r_count) begin
                    dir_we    = 1'b1;
                    dir_waddr = AW'(r_i);
                    dir_wid   = dir_rid;
                    dir_woff  = dir_roff - r_len;
                    dir_raddr = AW'(r_i + 2'd2);
                    n_i       = r_i + 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    n_end   = r_end - r_len;
                    if (r_after) begin
                        n_state = S_APPEND;
                    end else begin
                        n_ovalid  = 1'b1;
                        n_ostatus = ST_OK;
                        n_orbyte  = '0;
                        n_oslen   = '0;
                        n_otid    = r_id;
                        n_ocount  = FW_COUNT'(r_count - 1'b1);
                        n_state   = S_IDLE;
                    end
                end
            end

            S_APPEND: begin
                n_ovalid = 1'b1;
                n_orbyte = '0;
                n_oslen  = '0;
                n_otid   = r_id;
                n_ocount = FW_COUNT'(r_count);
                n_state  = S_IDLE;
                if (CMPW'(r_count) >= CMPW'(MAX_TAGS)) begin
                    n_ostatus = ST_FULL;
                    n_ws      = ST_FULL;
                end else if (CMPW'(r_vlen) > CMPW'(BUF_END - r_end)) begin
                    n_ostatus = ST_NO_ROOM;
                    n_ws      = ST_NO_ROOM;
                end else begin
                    dir_we    = 1'b1;
                    dir_waddr = AW'(r_count);
                    dir_wid   = r_id;
                    dir_woff  = r_end;
                    if (r_vlen != '0) begin
                        buf_we    = 1'b1;
                        buf_waddr = BW'(r_end);
                    end
                    n_count   = r_count + 1'b1;
                    n_end     = r_end + OW'(r_vlen);
                    n_ostatus = ST_OK;
                    n_ws      = ST_OK;
                    n_oslen   = r_vlen;
                    n_ocount  = FW_COUNT'(r_count + 1'b1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_count  <= '0;
            r_end    <= '0;
            r_ws     <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_count  <= n_count;
            r_end    <= n_end;
            r_ws     <= n_ws;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_id      <= n_id;
        r_idx     <= n_idx;
        r_vlen    <= n_vlen;
        r_data    <= n_data;
        r_i       <= n_i;
        r_k       <= n_k;
        r_found   <= n_found;
        r_after   <= n_after;
        r_off     <= n_off;
        r_len     <= n_len;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_pend    <= n_pend;
        r_ostatus <= n_ostatus;
        r_orbyte  <= n_orbyte;
        r_oslen   <= n_oslen;
        r_otid    <= n_otid;
        r_ocount  <= n_ocount;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_read_byte     = r_orbyte;
    assign o_stored_length = r_oslen;
    assign o_tag_id        = r_otid;
    assign o_entry_count   = r_ocount;

endmodule

// ===== hdl/tvs_dir_ram.sv =====
// Directory memory: tag ID and value offset per entry, one write and one read port.
module tvs_dir_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int OW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wid,
    input  logic [OW-1:0] i_woff,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rid,
    output logic [OW-1:0] o_roff
);
    logic [15:0]   r_id_mem  [DEPTH];
    logic [OW-1:0] r_off_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_id_mem[i_waddr]  <= i_wid;
            r_off_mem[i_waddr] <= i_woff;
        end
        o_rid  <= r_id_mem[i_raddr];
        o_roff <= r_off_mem[i_raddr];
    end

endmodule

// ===== hdl/tvs_buf_ram.sv =====
// Value byte buffer: one write and one registered read port.
module tvs_buf_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
